>>> rtl/repetition_penalty_unit_macros.svh
// ---------------------------------------------------------------------------
// Repetition penalty unit assertion macros
// Shared property forms for the checker of the repetition penalty unit.
// ---------------------------------------------------------------------------
`ifndef REPETITION_PENALTY_UNIT_MACROS_SVH
`define REPETITION_PENALTY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RPU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("repetition_penalty_unit: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define RPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("repetition_penalty_unit: next-cycle check failed");

// Implication after a fixed number of cycles, disabled while reset is high.
`define RPU_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("repetition_penalty_unit: delayed check failed");

`endif

>>> rtl/rpu_pkg.sv
// ---------------------------------------------------------------------------
// Repetition penalty package
// Sizes, codes and word types shared by the repetition penalty unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpu_pkg;

  localparam int VOCAB_DEPTH = 65536;
  localparam int ADDR_W      = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
  localparam int VOCAB_W     = 17;
  localparam int DEPTH_W     = $clog2(VOCAB_DEPTH + 1);
  localparam int LIM_W       = (DEPTH_W > VOCAB_W) ? DEPTH_W : VOCAB_W;
  localparam int FACTOR_W    = 16;
  localparam int LOGIT_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int PROD_W      = 48;
  localparam int FRAC_SHIFT  = 12;
  localparam int SCALED_W    = PROD_W - FRAC_SHIFT;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = VOCAB_W;

  localparam logic [VOCAB_W-1:0]         VOCAB_RESET  = 17'd65536;
  localparam logic [FACTOR_W-1:0]        FACTOR_RESET = 16'd4096;
  localparam logic signed [LOGIT_W-1:0]  LOGIT_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [LOGIT_W-1:0]  LOGIT_MIN    = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_MARK     = 2'd0,
    CMD_PENALIZE = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOCAB       = 2'd0,
    REG_PENALTY     = 2'd1,
    REG_INV_PENALTY = 2'd2
  } reg_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [LOGIT_W-1:0] token;
    logic signed [LOGIT_W-1:0] logit_value;
    logic                      last_logit;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        logit_index;
    logic signed [LOGIT_W-1:0] logit_result;
    logic                      was_penalized;
    logic                      last_out;
  } result_t;

  // Penalize word in flight, aligned with the bitmap read data.
  typedef struct packed {
    logic                      valid;
    logic                      in_range;
    logic signed [LOGIT_W-1:0] logit;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } lookup_t;

endpackage

>>> rtl/repetition_penalty_unit.sv
// ---------------------------------------------------------------------------
// Repetition penalty unit
// Seen-token bitmap with a penalty scaler for a stream of Q16.16 logits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// A word is taken at each clock edge where start is high and busy is low, one
// word per cycle. Mark words set one bit of a single-bit-wide bitmap memory of
// VOCAB_DEPTH entries; a penalize word reads that memory and its result shows
// on result for one cycle with done high, once the word has passed the lookup
// register, the multiply stage and the result register; mark and clear words
// give no result. The receiver cannot stall, so results leave as they come.
// Busy is high after reset and after each clear word, while the control sweeps
// the bitmap back to zero one entry per cycle through the memory's one write
// port. Write configuration only while no penalize word is in flight.

module repetition_penalty_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  rpu_pkg::item_t                  item,
  output logic                            busy,
  output logic                            done,
  output rpu_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [rpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [rpu_pkg::VOCAB_W-1:0]   vocab_in_use;
  logic [rpu_pkg::FACTOR_W-1:0]  penalty;
  logic [rpu_pkg::FACTOR_W-1:0]  inv_penalty;

  logic                          mem_we;
  logic [rpu_pkg::ADDR_W-1:0]    mem_waddr;
  logic                          mem_wdata;
  logic [rpu_pkg::ADDR_W-1:0]    mem_raddr;
  logic                          mem_rdata;
  rpu_pkg::lookup_t              look;

  // Configuration registers: write on cfg_we, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_in_use <= rpu_pkg::VOCAB_RESET;
      penalty      <= rpu_pkg::FACTOR_RESET;
      inv_penalty  <= rpu_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpu_pkg::REG_VOCAB: begin
          vocab_in_use <= cfg_data;
        end
        rpu_pkg::REG_PENALTY: begin
          penalty <= cfg_data[rpu_pkg::FACTOR_W-1:0];
        end
        rpu_pkg::REG_INV_PENALTY: begin
          inv_penalty <= cfg_data[rpu_pkg::FACTOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front end: accept words, run the clearing sweep, drive the bitmap.
  rpu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .vocab_in_use (vocab_in_use),
    .busy         (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .look         (look)
  );

  // Seen-token bitmap. A mark written at one edge is visible to a read at
  // the next, so mark-then-penalize on the same token needs no forwarding.
  rpu_ram #(
    .WIDTH (1),
    .DEPTH (rpu_pkg::VOCAB_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Back end: multiply stage, then shift, saturate and register the result.
  rpu_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .look        (look),
    .seen        (mem_rdata),
    .penalty     (penalty),
    .inv_penalty (inv_penalty),
    .done        (done),
    .result      (result)
  );

endmodule

>>> rtl/rpu_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rpu_ctrl.sv
// ---------------------------------------------------------------------------
// Repetition penalty control
// Accepts words, sweeps the bitmap clear and issues bitmap reads and writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpu_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rpu_pkg::item_t                item,
  input  logic [rpu_pkg::VOCAB_W-1:0]   vocab_in_use,
  output logic                          busy,
  output logic                          mem_we,
  output logic [rpu_pkg::ADDR_W-1:0]    mem_waddr,
  output logic                          mem_wdata,
  output logic [rpu_pkg::ADDR_W-1:0]    mem_raddr,
  output rpu_pkg::lookup_t              look
);

  rpu_pkg::state_e                state, state_next;
  logic [rpu_pkg::ADDR_W-1:0]     sweep_cnt, sweep_cnt_next;
  logic [rpu_pkg::LIM_W-1:0]      limit;
  logic [rpu_pkg::LIM_W-1:0]      vocab_ext;
  logic [rpu_pkg::ADDR_W-1:0]     addr;
  logic                           in_range;
  logic                           accept;

  // Valid token: 0 <= token < min(vocab_in_use, depth).
  assign vocab_ext = rpu_pkg::LIM_W'(vocab_in_use);
  assign limit     = (vocab_ext < rpu_pkg::LIM_W'(rpu_pkg::VOCAB_DEPTH)) ?
                     vocab_ext : rpu_pkg::LIM_W'(rpu_pkg::VOCAB_DEPTH);
  assign in_range  = !item.token[rpu_pkg::LOGIT_W-1] &&
                     (item.token[rpu_pkg::LOGIT_W-2:0] < (rpu_pkg::LOGIT_W-1)'(limit));
  assign addr      = item.token[rpu_pkg::ADDR_W-1:0];
  assign mem_raddr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpu_pkg::ST_CLEAR;
      sweep_cnt <= '0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweep_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    sweep_cnt_next = sweep_cnt;
    busy           = 1'b0;
    accept         = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = addr;
    mem_wdata      = 1'b1;
    case (state)
      rpu_pkg::ST_CLEAR: begin
        busy      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt;
        mem_wdata = 1'b0;
        if (sweep_cnt == rpu_pkg::ADDR_W'(rpu_pkg::VOCAB_DEPTH - 1)) begin
          state_next     = rpu_pkg::ST_RUN;
          sweep_cnt_next = '0;
        end else begin
          sweep_cnt_next = sweep_cnt + 1'b1;
        end
      end
      rpu_pkg::ST_RUN: begin
        accept = start;
        if (start && item.cmd == rpu_pkg::CMD_MARK && in_range) begin
          mem_we = 1'b1;
        end
        if (start && item.cmd == rpu_pkg::CMD_CLEAR) begin
          state_next = rpu_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_next = rpu_pkg::ST_CLEAR;
      end
    endcase
  end

  // Hold the penalize word alongside the bitmap read.
  always_ff @(posedge clk) begin
    if (rst) begin
      look.valid <= 1'b0;
    end else begin
      look.valid <= accept && (item.cmd == rpu_pkg::CMD_PENALIZE);
    end
    look.in_range <= in_range;
    look.logit    <= item.logit_value;
    look.index    <= item.token[rpu_pkg::INDEX_W-1:0];
    look.last     <= item.last_logit;
  end

endmodule

>>> rtl/rpu_scale.sv
// ---------------------------------------------------------------------------
// Repetition penalty scaler
// Multiplies a marked logit by its Q4.12 factor, shifts and saturates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpu_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  rpu_pkg::lookup_t              look,
  input  logic                          seen,
  input  logic [rpu_pkg::FACTOR_W-1:0]  penalty,
  input  logic [rpu_pkg::FACTOR_W-1:0]  inv_penalty,
  output logic                          done,
  output rpu_pkg::result_t              result
);

  logic [rpu_pkg::FACTOR_W-1:0]          factor;
  logic signed [rpu_pkg::PROD_W-1:0]     prod;
  logic                                  a_valid;
  logic                                  a_hit;
  logic                                  a_last;
  logic signed [rpu_pkg::LOGIT_W-1:0]    a_logit;
  logic [rpu_pkg::INDEX_W-1:0]           a_index;
  logic signed [rpu_pkg::PROD_W-1:0]     a_prod;
  logic signed [rpu_pkg::SCALED_W-1:0]   scaled;
  logic                                  overflow;
  logic signed [rpu_pkg::LOGIT_W-1:0]    sat;

  assign factor = (look.logit > 0) ? inv_penalty : penalty;
  assign prod   = rpu_pkg::PROD_W'(look.logit) *
                  rpu_pkg::PROD_W'($signed({1'b0, factor}));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= look.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_hit   <= look.in_range && seen;
    a_last  <= look.last;
    a_logit <= look.logit;
    a_index <= look.index;
    a_prod  <= prod;
  end

  // Floor shift, then clamp when the bits above the sign disagree.
  assign scaled   = a_prod[rpu_pkg::PROD_W-1:rpu_pkg::FRAC_SHIFT];
  assign overflow = scaled[rpu_pkg::SCALED_W-1:rpu_pkg::LOGIT_W-1] !=
                    {(rpu_pkg::SCALED_W-rpu_pkg::LOGIT_W+1){scaled[rpu_pkg::SCALED_W-1]}};
  assign sat      = !overflow ? scaled[rpu_pkg::LOGIT_W-1:0] :
                    (scaled[rpu_pkg::SCALED_W-1] ? rpu_pkg::LOGIT_MIN : rpu_pkg::LOGIT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.logit_index   <= a_index;
    result.logit_result  <= a_hit ? sat : a_logit;
    result.was_penalized <= a_hit;
    result.last_out      <= a_last;
  end

endmodule

>>> rtl/rpu_checker.sv
// ---------------------------------------------------------------------------
// Repetition penalty checker
// Port-level checks on word acceptance, result timing and the clearing sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "repetition_penalty_unit_macros.svh"

module rpu_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  rpu_pkg::item_t                  item,
  input  logic                            busy,
  input  logic                            done,
  input  rpu_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [rpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic take_penalize;
  logic take_clear;
  logic cfg_seen;

  assign take_penalize = start && !busy && (item.cmd == rpu_pkg::CMD_PENALIZE);
  assign take_clear    = start && !busy && (item.cmd == rpu_pkg::CMD_CLEAR);
  assign cfg_seen      = cfg_we && (cfg_index != cfg_index) && (cfg_data != cfg_data);

  `RPU_ASSERT_DELAY(a_penalize_returns, clk, rst, take_penalize, 3, done)
  `RPU_ASSERT_IMP(a_done_has_source, clk, rst, done, $past(take_penalize, 3) && !cfg_seen)
  `RPU_ASSERT_IMP(a_index_follows, clk, rst, done, result.logit_index == $past(item.token[15:0], 3))
  `RPU_ASSERT_NEXT(a_clear_sweeps, clk, rst, take_clear, busy)
  `RPU_ASSERT_IMP(a_reset_sweeps, clk, rst, $fell(rst), busy)

endmodule

bind repetition_penalty_unit rpu_checker u_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Repetition penalty unit testbench
// Drives mark, penalize and clear words through the unit under changing
// register settings and checks every penalized logit against a predictor
// that keeps its own copy of the seen-token bitmap.
// ---------------------------------------------------------------------------

module tb_top;
  import rpu_pkg::*;

  // cmd 3 has no meaning to the unit; the word is dropped without a result
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET  = 1050;
  localparam int         PHASE_ITEMS  = 100;
  localparam int         DRAIN_CYCLES = 8;
  // a clear sweep holds busy across the whole bitmap; the limit allows four sweeps
  localparam int         STALL_LIMIT  = 4 * VOCAB_DEPTH;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  item_t                 item = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  repetition_penalty_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Predictor state: register copies and the seen-token bitmap
  // ------------------------------------------------------------------------
  logic [VOCAB_W-1:0]  vocab_reg = VOCAB_RESET;
  logic [FACTOR_W-1:0] pen_reg   = FACTOR_RESET;
  logic [FACTOR_W-1:0] inv_reg   = FACTOR_RESET;
  bit                  mark_map [VOCAB_DEPTH];

  item_t   word_queue [$];   // words waiting for the driver
  result_t logit_queue [$];  // penalized logits still to come out

  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned n_useful = 0;
  int unsigned n_logits = 0;
  int unsigned n_hits = 0;
  int unsigned n_clears = 0;
  int unsigned n_writes = 0;
  int unsigned errors = 0;

  // Number of valid token ids under the current vocab setting.
  function automatic longint vocab_limit();
    return (longint'(vocab_reg) > VOCAB_DEPTH) ? longint'(VOCAB_DEPTH) : longint'(vocab_reg);
  endfunction

  function automatic bit token_ok(logic signed [LOGIT_W-1:0] tok);
    longint t;
    t = longint'(tok);
    return (t >= 0) && (t < vocab_limit());
  endfunction

  // Multiply by a Q4.12 factor, floor-shift by 12 and clamp to 32 bits.
  function automatic logic signed [LOGIT_W-1:0] scale_logit(logic signed [LOGIT_W-1:0] v,
                                                             logic [FACTOR_W-1:0] f);
    longint prod;
    prod = longint'(v) * longint'({1'b0, f});
    prod = prod >>> FRAC_SHIFT;
    if (prod > longint'(LOGIT_MAX)) return LOGIT_MAX;
    if (prod < longint'(LOGIT_MIN)) return LOGIT_MIN;
    return prod[LOGIT_W-1:0];
  endfunction

  function automatic result_t penalize_logit(item_t w);
    result_t r;
    r.logit_index   = w.token[INDEX_W-1:0];
    r.logit_result  = w.logit_value;
    r.was_penalized = 1'b0;
    r.last_out      = w.last_logit;
    if (token_ok(w.token)) begin
      if (mark_map[int'(w.token)]) begin
        r.was_penalized = 1'b1;
        r.logit_result  = (w.logit_value > 0) ? scale_logit(w.logit_value, inv_reg)
                                              : scale_logit(w.logit_value, pen_reg);
      end
    end
    return r;
  endfunction

  // Advance the predictor by one accepted word.
  task automatic take_word(item_t w);
    result_t r;
    case (w.cmd)
      CMD_MARK: begin
        if (token_ok(w.token)) mark_map[int'(w.token)] = 1'b1;
      end
      CMD_CLEAR: begin
        mark_map = '{default: 1'b0};
        n_clears++;
      end
      CMD_PENALIZE: begin
        r = penalize_logit(w);
        logit_queue.push_back(r);
        n_logits++;
        if (r.was_penalized) n_hits++;
      end
      default: begin
      end
    endcase
    // count after the push so a waiter never sees the word taken but not predicted
    n_taken++;
  endtask

  // ------------------------------------------------------------------------
  // Driver: present words from word_queue, random gap after each one taken
  // ------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;

  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        take_word(item);
        next_start = 1'b0;
        // mostly random gaps, now and then a run of back-to-back words
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 24) == 0) begin
          calm_left = $urandom_range(16, 48);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 16);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_queue.size() > 0) begin
          item <= word_queue.pop_front();
          next_start = 1'b1;
        end
      end
      // one assignment per edge keeps start high across back-to-back words
      start <= next_start;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: every done cycle must match the oldest predicted logit
  // ------------------------------------------------------------------------
  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done !== 1'b0) begin
      if (logit_queue.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, result);
        errors++;
      end else begin
        want = logit_queue.pop_front();
        if (result.logit_index !== want.logit_index)
          report("logit_index", 32'(want.logit_index), 32'(result.logit_index));
        if (result.logit_result !== want.logit_result)
          report("logit_result", want.logit_result, result.logit_result);
        if (result.was_penalized !== want.was_penalized)
          report("was_penalized", 32'(want.was_penalized), 32'(result.was_penalized));
        if (result.last_out !== want.last_out)
          report("last_out", 32'(want.last_out), 32'(result.last_out));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Watchdog: too long without a word taken, a result or a register write
  // ------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1 || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d logits outstanding", $time, logit_queue.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic send(logic [1:0] c, logic [31:0] tok, logic [31:0] lv, logic lst);
    item_t w;
    w.cmd         = c;
    w.token       = tok;
    w.logit_value = lv;
    w.last_logit  = lst;
    word_queue.push_back(w);
    n_sent++;
    if (c != CMD_UNUSED) n_useful++;
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_VOCAB:       vocab_reg = val;
      REG_PENALTY:     pen_reg   = val[FACTOR_W-1:0];
      REG_INV_PENALTY: inv_reg   = val[FACTOR_W-1:0];
      default: begin
      end
    endcase
    n_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every word is taken, every logit is back and no sweep runs.
  task automatic wait_quiet();
    while (n_taken != n_sent) @(posedge clk);
    while (logit_queue.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_logit();
    case ($urandom_range(0, 7))
      0: return LOGIT_MAX;
      1: return LOGIT_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      4, 5: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_factor();
    case ($urandom_range(0, 4))
      0: return CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
      1: return $urandom_range(0, 1) ? 17'd0 : 17'd65535;
      2: return 17'd1;
      default: return CFG_DATA_W'($urandom_range(2048, 12288));
    endcase
  endfunction

  // Marks in a token window (now and then just below it), then a penalize pass over that window.
  // A broken pass may stop early, carries stray words and may clear the bitmap.
  int unsigned clears_left = 5;

  task automatic gen_pass(bit whole);
    longint lo;
    longint lim;
    longint t;
    int     len;
    int     stop;
    lim = vocab_limit();
    case ($urandom_range(0, 2))
      0: lo = 0;
      1: lo = lim - 12;   // straddle the top of the valid range
      default: lo = (lim > 24) ? longint'($urandom_range(0, int'(lim - 24))) : 0;
    endcase
    len = $urandom_range(4, 24);
    repeat ($urandom_range(1, 8)) begin
      t = lo + $urandom_range(0, len - 1);
      if ($urandom_range(0, 7) == 0) t = lo - 1;
      send(CMD_MARK, t[31:0], $urandom, 1'($urandom_range(0, 1)));
    end
    stop = whole ? len : $urandom_range(1, len);
    for (int i = 0; i < stop; i++) begin
      t = lo + i;
      if (!whole && $urandom_range(0, 4) == 0) send(CMD_UNUSED, t[31:0], rand_logit(), 1'b0);
      send(CMD_PENALIZE, t[31:0], rand_logit(),
           whole ? (i == len - 1) : logic'($urandom_range(0, 1)));
    end
    if (!whole && clears_left > 0 && $urandom_range(0, 2) == 0) begin
      send(CMD_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)));
      clears_left--;
    end
  endtask

  // Words with every field random; clears are kept out since each one is slow.
  task automatic gen_noise();
    logic [1:0] c;
    repeat (8) begin
      c = 2'($urandom_range(0, 3));
      if (c == CMD_CLEAR) c = CMD_PENALIZE;
      send(c, $urandom, rand_logit(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic set_phase_regs(int p);
    logic [CFG_DATA_W-1:0] v;
    case (p)
      0: v = 17'd0;
      1: v = 17'd1;
      2: v = 17'd65536;
      3: v = 17'h1FFFF;
      default: begin
        case ($urandom_range(0, 3))
          0: v = CFG_DATA_W'($urandom_range(1, 300));
          1: v = 17'd65536;
          2: v = CFG_DATA_W'($urandom_range(24, 64));
          default: v = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
        endcase
      end
    endcase
    write_reg(REG_VOCAB, v);
    case (p)
      0: begin
        write_reg(REG_PENALTY, 17'd0);
        write_reg(REG_INV_PENALTY, 17'd0);
      end
      1: begin
        write_reg(REG_PENALTY, 17'd1);
        write_reg(REG_INV_PENALTY, 17'd1);
      end
      2: begin
        write_reg(REG_PENALTY, 17'd65535);
        write_reg(REG_INV_PENALTY, 17'd65535);
      end
      default: begin
        write_reg(REG_PENALTY, rand_factor());
        write_reg(REG_INV_PENALTY, rand_factor());
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    int phase;
    int unsigned phase_end;
    int unsigned pick;

    mark_map = '{default: 1'b0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: bitmap edges, ids out of range, repeated mark, unused cmd.
    send(CMD_MARK, 32'd0, 32'd0, 1'b0);
    send(CMD_MARK, 32'd65535, 32'd0, 1'b0);
    send(CMD_MARK, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send(CMD_MARK, 32'd65536, 32'd0, 1'b0);
    send(CMD_MARK, 32'h7FFF_FFFF, 32'd0, 1'b1);
    send(CMD_MARK, 32'h8000_0000, 32'd0, 1'b0);
    send(CMD_MARK, 32'd0, 32'd0, 1'b0);
    send(CMD_PENALIZE, 32'd0, LOGIT_MAX, 1'b0);
    send(CMD_PENALIZE, 32'd65535, LOGIT_MIN, 1'b0);
    send(CMD_PENALIZE, 32'hFFFF_FFFF, 32'd1, 1'b0);
    send(CMD_PENALIZE, 32'd65536, 32'd7, 1'b0);
    send(CMD_PENALIZE, 32'd3, 32'hFFFF_FFFB, 1'b0);
    send(CMD_UNUSED, 32'd3, 32'd9, 1'b1);
    send(CMD_PENALIZE, 32'd0, 32'd0, 1'b1);
    wait_quiet();

    // Largest factors: saturation both ways, floor on negative products, clear.
    write_reg(REG_PENALTY, 17'd65535);
    write_reg(REG_INV_PENALTY, 17'd65535);
    send(CMD_PENALIZE, 32'd0, LOGIT_MAX, 1'b0);
    send(CMD_PENALIZE, 32'd65535, LOGIT_MIN, 1'b0);
    send(CMD_PENALIZE, 32'd0, 32'd1, 1'b0);
    send(CMD_PENALIZE, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send(CMD_CLEAR, 32'd0, 32'd0, 1'b0);
    send(CMD_PENALIZE, 32'd0, 32'd100, 1'b1);

    // Random phases, new register settings each time, extremes first.
    phase = 0;
    while (n_useful < ITEM_TARGET) begin
      wait_quiet();
      set_phase_regs(phase);
      phase_end = n_useful + PHASE_ITEMS;
      while (n_useful < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) gen_pass(1'b1);
        else if (pick < 9) gen_pass(1'b0);
        else gen_noise();
      end
      phase++;
    end
    wait_quiet();

    $display("ran %0d words over %0d register phases, %0d register writes",
             n_taken, phase, n_writes);
    $display("checked %0d logits (%0d penalized) across %0d bitmap clears",
             n_logits, n_hits, n_clears);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rpu_pkg.sv
rtl/rpu_ram.sv
rtl/rpu_ctrl.sv
rtl/rpu_scale.sv
rtl/repetition_penalty_unit.sv
rtl/rpu_checker.sv
dv/tb_top.sv
